// ----- sv/canaf_pkg.sv -----
// canaf_pkg: shared types and constants of the CAN receive acceptance filter
// holds field widths, result codes, controller states and the ctrl/datapath structs
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package canaf_pkg;

  // field widths
  localparam int unsigned ACT_W       = 6;
  localparam int unsigned IDX_W       = 5;
  localparam int unsigned ID_W        = 11;
  localparam int unsigned FID_W       = 29;
  localparam int unsigned HIT_W       = 5;
  localparam int unsigned STAT_W      = 3;
  localparam int unsigned APB_AW      = 3;
  localparam int unsigned APB_DW      = 32;

  // default bank size and active count reset value
  localparam int unsigned ENTRIES_DEF = 32;
  localparam logic [ACT_W-1:0] ACT_RST = ACT_W'(32);

  // register indexes
  localparam logic REG_ACTIVE = 1'b0;
  localparam logic REG_NORMAL = 1'b1;

  // input word modes
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_FRAME = 1'b1;

  // result codes
  typedef enum logic [STAT_W-1:0] {
    RS_WR_OK    = 3'd0,
    RS_WR_REJ   = 3'd1,
    RS_IGNORED  = 3'd2,
    RS_RX_ERR   = 3'd3,
    RS_NO_MATCH = 3'd4,
    RS_UNBOUND  = 3'd5,
    RS_DISPATCH = 3'd6
  } res_code_e;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_CLASSIFY,
    S_SCAN,
    S_FINISH
  } state_e;

  // one stored filter entry
  typedef struct packed {
    logic [ID_W-1:0] ident;
    logic [ID_W-1:0] mask;
    logic            rtr;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic      wr_en;
    logic      scan_start;
    logic      scan_step;
    logic      res_load;
    res_code_e res_code;
    logic      res_use_hit;
    logic      out_load;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_write;
    logic in_range;
    logic ignored;
    logic rx_err;
    logic count_zero;
    logic hit;
    logic hit_bound;
    logic scan_end;
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- sv/can_rx_acceptance_filter.sv -----
// can_rx_acceptance_filter: top level of the CAN receive acceptance filter bank
// holds the APB registers and joins canaf_ctrl and canaf_dp; uses canaf_pkg
//
// Usage:
//   Input words arrive on in_valid_i/in_stall_o. mode_i = 0 writes filter entry
//   entry_index_i (rejected unless below the active count), mode_i = 1 presents a
//   received frame that is matched against entries 0 .. count-1 in order, stopping
//   at the first hit. Every input word gives one result word (status_o,
//   hit_index_o) on out_valid_o/out_stall_i.
//   Registers over APB: offset 0 active_entries (6 bits, reset 32, values above
//   ENTRIES act as ENTRIES), offset 4 normal_mode (1 bit, reset 0). Write them
//   only while no word is in flight.
//   Flow: an entry write, ignored frame, receive error or empty bank gets its
//   result in the classify state; a scanned frame compares entries 0 .. count-1
//   until the first hit or the last one, read one by one through the
//   one-entry-per-cycle read port of the entry store. One word is in work at a
//   time; the next is accepted once the result is in the output register.
//   A stalled receiver holds the result; one further word can be accepted and
//   processed, then it waits until the output register empties.
//   Reset clears the bound flags (all entries unbound) and the registers at once;
//   no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module can_rx_acceptance_filter #(
  parameter int unsigned ENTRIES = canaf_pkg::ENTRIES_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // input channel
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic                           mode_i,
  input  wire logic [canaf_pkg::IDX_W-1:0]    entry_index_i,
  input  wire logic [canaf_pkg::ID_W-1:0]     entry_ident_i,
  input  wire logic [canaf_pkg::ID_W-1:0]     entry_mask_i,
  input  wire logic                           entry_rtr_i,
  input  wire logic [canaf_pkg::FID_W-1:0]    frame_id_i,
  input  wire logic                           frame_err_i,
  input  wire logic                           frame_rtr_i,
  input  wire logic                           frame_eff_i,
  input  wire logic                           frame_short_i,
  // output channel
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [canaf_pkg::STAT_W-1:0]        status_o,
  output logic [canaf_pkg::HIT_W-1:0]         hit_index_o,
  // register port
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [canaf_pkg::APB_AW-1:0]   paddr,
  input  wire logic [canaf_pkg::APB_DW-1:0]   pwdata,
  output logic [canaf_pkg::APB_DW-1:0]        prdata,
  output logic                                pready
);

  logic [canaf_pkg::ACT_W-1:0] active_q;
  logic                        normal_q;
  logic [canaf_pkg::ACT_W-1:0] count;
  logic                        reg_wr;
  logic                        in_accept;
  canaf_pkg::dp_cmd_t          cmd;
  canaf_pkg::dp_stat_t         st;

  // register writes
  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= canaf_pkg::ACT_RST;
      normal_q <= 1'b0;
    end else if (reg_wr) begin
      if (paddr[2] == canaf_pkg::REG_ACTIVE) begin
        active_q <= pwdata[canaf_pkg::ACT_W-1:0];
      end else begin
        normal_q <= pwdata[0];
      end
    end
  end

  // register reads
  assign prdata = (paddr[2] == canaf_pkg::REG_ACTIVE) ? canaf_pkg::APB_DW'(active_q)
                                                     : canaf_pkg::APB_DW'(normal_q);

  // effective active count, limited to the bank size
  always_comb begin
    if (32'(active_q) > 32'(ENTRIES)) begin
      count = canaf_pkg::ACT_W'(ENTRIES);
    end else begin
      count = active_q;
    end
  end

  assign in_accept = in_valid_i && !in_stall_o;

  canaf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_accept_i (in_accept),
    .out_stall_i (out_stall_i),
    .st_i        (st),
    .cmd_o       (cmd),
    .busy_o      (in_stall_o),
    .out_valid_o (out_valid_o)
  );

  canaf_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_accept_i   (in_accept),
    .mode_i        (mode_i),
    .entry_index_i (entry_index_i),
    .entry_ident_i (entry_ident_i),
    .entry_mask_i  (entry_mask_i),
    .entry_rtr_i   (entry_rtr_i),
    .frame_id_i    (frame_id_i),
    .frame_err_i   (frame_err_i),
    .frame_rtr_i   (frame_rtr_i),
    .frame_eff_i   (frame_eff_i),
    .frame_short_i (frame_short_i),
    .count_i       (count),
    .normal_mode_i (normal_q),
    .cmd_i         (cmd),
    .st_o          (st),
    .status_o      (status_o),
    .hit_index_o   (hit_index_o)
  );

  // an accepted word keeps the block busy for the next cycle
  a_busy_after_accept: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> in_stall_o
  ) else $error("block not busy after accepting a word");

  // only hit results carry a hit index
  a_hit_index_zero: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != canaf_pkg::RS_UNBOUND && status_o != canaf_pkg::RS_DISPATCH)
      |-> (hit_index_o == '0)
  ) else $error("nonzero hit index on a result without a hit");

  // a stalled result word stays valid and unchanged
  a_stall_holds: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i)
      |=> (out_valid_o && $stable(status_o) && $stable(hit_index_o))
  ) else $error("result word changed while stalled");

  // matched results only leave the block in normal mode
  a_match_needs_normal: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == canaf_pkg::RS_UNBOUND || status_o == canaf_pkg::RS_DISPATCH))
      |-> normal_q
  ) else $error("match reported while normal mode is off");

endmodule

`default_nettype wire

// ----- sv/canaf_ram.sv -----
// canaf_ram: generic single write port, single read port RAM with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module canaf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- sv/canaf_ctrl.sv -----
// canaf_ctrl: controller state machine of the acceptance filter
// sequences classify, entry scan and result hand-off; uses canaf_pkg
`timescale 1ns / 1ps
`default_nettype none

module canaf_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_accept_i,
  input  wire logic               out_stall_i,
  input  wire canaf_pkg::dp_stat_t st_i,
  output canaf_pkg::dp_cmd_t      cmd_o,
  output logic                    busy_o,
  output logic                    out_valid_o
);

  canaf_pkg::state_e state_q, state_d;
  logic              out_vld_q, out_vld_d;
  logic              out_free;

  // state and output valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= canaf_pkg::S_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign out_free = !out_vld_q || !out_stall_i;

  // next state and commands
  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    cmd_o.res_code = canaf_pkg::RS_WR_OK;
    out_vld_d = out_vld_q && out_stall_i;

    case (state_q)
      canaf_pkg::S_IDLE: begin
        if (in_accept_i) begin
          state_d = canaf_pkg::S_CLASSIFY;
        end
      end

      canaf_pkg::S_CLASSIFY: begin
        cmd_o.res_load = 1'b1;
        state_d        = canaf_pkg::S_FINISH;
        if (st_i.is_write) begin
          cmd_o.wr_en    = st_i.in_range;
          cmd_o.res_code = st_i.in_range ? canaf_pkg::RS_WR_OK : canaf_pkg::RS_WR_REJ;
        end else if (st_i.ignored) begin
          cmd_o.res_code = canaf_pkg::RS_IGNORED;
        end else if (st_i.rx_err) begin
          cmd_o.res_code = canaf_pkg::RS_RX_ERR;
        end else if (st_i.count_zero) begin
          cmd_o.res_code = canaf_pkg::RS_NO_MATCH;
        end else begin
          cmd_o.res_load   = 1'b0;
          cmd_o.scan_start = 1'b1;
          state_d          = canaf_pkg::S_SCAN;
        end
      end

      canaf_pkg::S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (st_i.hit) begin
          cmd_o.res_load    = 1'b1;
          cmd_o.res_use_hit = 1'b1;
          cmd_o.res_code    = st_i.hit_bound ? canaf_pkg::RS_DISPATCH
                                             : canaf_pkg::RS_UNBOUND;
          state_d           = canaf_pkg::S_FINISH;
        end else if (st_i.scan_end) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_code = canaf_pkg::RS_NO_MATCH;
          state_d        = canaf_pkg::S_FINISH;
        end
      end

      canaf_pkg::S_FINISH: begin
        // move the word into the output register once it is free
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_vld_d      = 1'b1;
          state_d        = canaf_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = canaf_pkg::S_IDLE;
      end
    endcase
  end

  assign busy_o      = (state_q != canaf_pkg::S_IDLE);
  assign out_valid_o = out_vld_q;

endmodule

`default_nettype wire

// ----- sv/canaf_dp.sv -----
// canaf_dp: datapath of the acceptance filter
// item latch, entry store, bound flags, scan counters, match logic, result registers
// depends on canaf_pkg and canaf_ram
`timescale 1ns / 1ps
`default_nettype none

module canaf_dp #(
  parameter int unsigned ENTRIES = canaf_pkg::ENTRIES_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_accept_i,
  input  wire logic                            mode_i,
  input  wire logic [canaf_pkg::IDX_W-1:0]     entry_index_i,
  input  wire logic [canaf_pkg::ID_W-1:0]      entry_ident_i,
  input  wire logic [canaf_pkg::ID_W-1:0]      entry_mask_i,
  input  wire logic                            entry_rtr_i,
  input  wire logic [canaf_pkg::FID_W-1:0]     frame_id_i,
  input  wire logic                            frame_err_i,
  input  wire logic                            frame_rtr_i,
  input  wire logic                            frame_eff_i,
  input  wire logic                            frame_short_i,
  input  wire logic [canaf_pkg::ACT_W-1:0]     count_i,
  input  wire logic                            normal_mode_i,
  input  wire canaf_pkg::dp_cmd_t              cmd_i,
  output canaf_pkg::dp_stat_t                  st_o,
  output logic [canaf_pkg::STAT_W-1:0]         status_o,
  output logic [canaf_pkg::HIT_W-1:0]          hit_index_o
);

  localparam int unsigned AW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned EXT_W = AW + canaf_pkg::ACT_W;
  localparam int unsigned EW    = $bits(canaf_pkg::entry_t);

  // latched item
  logic                          mode_q;
  logic [canaf_pkg::IDX_W-1:0]   idx_q;
  canaf_pkg::entry_t             wr_ent_q;
  logic [canaf_pkg::ID_W-1:0]    fid_q;
  logic                          frtr_q;
  logic                          feff_q;
  logic                          fshort_q;
  logic                          zero_word_q;

  // scan state
  logic [canaf_pkg::ACT_W-1:0]   rd_cnt_q;
  logic [canaf_pkg::ACT_W-1:0]   cmp_cnt_q;
  logic                          cmp_vld_q;
  logic                          bound_rd_q;
  logic [ENTRIES-1:0]            bound_q;

  // results
  canaf_pkg::res_code_e          res_code_q;
  logic [canaf_pkg::HIT_W-1:0]   res_hit_q;
  logic [canaf_pkg::STAT_W-1:0]  out_status_q;
  logic [canaf_pkg::HIT_W-1:0]   out_hit_q;

  logic [EXT_W-1:0]              wr_ext, rd_ext;
  logic [AW-1:0]                 wr_addr, rd_addr;
  logic                          rd_more, rd_en;
  logic [EW-1:0]                 rd_data;
  canaf_pkg::entry_t             rd_ent;
  logic                          match_bound, match;

  // item latch
  always_ff @(posedge clk_i) begin
    if (in_accept_i) begin
      mode_q         <= mode_i;
      idx_q          <= entry_index_i;
      wr_ent_q.ident <= entry_ident_i;
      wr_ent_q.mask  <= entry_mask_i;
      wr_ent_q.rtr   <= entry_rtr_i;
      fid_q          <= frame_id_i[canaf_pkg::ID_W-1:0];
      frtr_q         <= frame_rtr_i;
      feff_q         <= frame_eff_i;
      fshort_q       <= frame_short_i;
      zero_word_q    <= (frame_id_i == '0) && !frame_err_i && !frame_rtr_i && !frame_eff_i;
    end
  end

  // entry addresses sized to the bank
  assign wr_ext  = EXT_W'(idx_q);
  assign wr_addr = wr_ext[AW-1:0];
  assign rd_ext  = EXT_W'(rd_cnt_q);
  assign rd_addr = rd_ext[AW-1:0];
  assign rd_more = (rd_cnt_q < count_i);
  assign rd_en   = cmd_i.scan_step && rd_more;

  // entry store
  canaf_ram #(
    .WIDTH (EW),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_ent_q),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  assign rd_ent = canaf_pkg::entry_t'(rd_data);

  // bound flags, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bound_q <= '0;
    end else if (cmd_i.wr_en) begin
      bound_q[wr_addr] <= 1'b1;
    end
  end

  // scan counters: read one entry a cycle, compare it the next
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_cnt_q  <= '0;
      cmp_cnt_q <= '0;
      cmp_vld_q <= 1'b0;
    end else if (cmd_i.scan_start) begin
      rd_cnt_q  <= '0;
      cmp_vld_q <= 1'b0;
    end else if (cmd_i.scan_step) begin
      cmp_vld_q <= rd_more;
      if (rd_more) begin
        rd_cnt_q  <= rd_cnt_q + 1'b1;
        cmp_cnt_q <= rd_cnt_q;
      end
    end
  end

  // bound flag read alongside the store
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      bound_rd_q <= bound_q[rd_addr];
    end
  end

  // entry match
  assign match_bound = !feff_q && (frtr_q == rd_ent.rtr) &&
                       (((fid_q ^ rd_ent.ident) & rd_ent.mask) == '0);
  assign match       = bound_rd_q ? match_bound : zero_word_q;

  // status to the controller
  always_comb begin
    st_o.is_write   = (mode_q == canaf_pkg::MODE_WRITE);
    st_o.in_range   = (canaf_pkg::ACT_W'(idx_q) < count_i);
    st_o.ignored    = !normal_mode_i;
    st_o.rx_err     = fshort_q;
    st_o.count_zero = (count_i == '0);
    st_o.hit        = cmp_vld_q && match;
    st_o.hit_bound  = bound_rd_q;
    st_o.scan_end   = cmp_vld_q && (cmp_cnt_q == (count_i - 1'b1));
  end

  // staged result and output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      res_code_q <= cmd_i.res_code;
      res_hit_q  <= cmd_i.res_use_hit ? canaf_pkg::HIT_W'(cmp_cnt_q) : '0;
    end
    if (cmd_i.out_load) begin
      out_status_q <= res_code_q;
      out_hit_q    <= res_hit_q;
    end
  end

  assign status_o    = out_status_q;
  assign hit_index_o = out_hit_q;

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// testbench: self-checking bench for the CAN receive acceptance filter bank
// predicts each result word from its own copy of the filter entries and registers
// depends on canaf_pkg and can_rx_acceptance_filter
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned NUM_ENTRIES = canaf_pkg::ENTRIES_DEF;
  localparam int unsigned UPPER_W     = canaf_pkg::FID_W - canaf_pkg::ID_W;
  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned SETTLE      = 4;
  localparam int unsigned TAIL        = 40;

  // one input word as driven on the ports
  typedef struct packed {
    logic                        mode;
    logic [canaf_pkg::IDX_W-1:0] entry_index;
    logic [canaf_pkg::ID_W-1:0]  entry_ident;
    logic [canaf_pkg::ID_W-1:0]  entry_mask;
    logic                        entry_rtr;
    logic [canaf_pkg::FID_W-1:0] frame_id;
    logic                        frame_err;
    logic                        frame_rtr;
    logic                        frame_eff;
    logic                        frame_short;
  } in_word_t;

  // one result word
  typedef struct packed {
    canaf_pkg::res_code_e        code;
    logic [canaf_pkg::HIT_W-1:0] hit;
  } filter_result_t;

  // filter bank shadow plus queue of results still to come
  class acceptance_scoreboard;
    logic [canaf_pkg::ID_W-1:0]  ident [NUM_ENTRIES];
    logic [canaf_pkg::ID_W-1:0]  mask  [NUM_ENTRIES];
    bit                          rtr   [NUM_ENTRIES];
    bit                          bound [NUM_ENTRIES];
    logic [canaf_pkg::ACT_W-1:0] active_cnt;
    bit                          normal_on;
    filter_result_t              pending_results[$];
    int unsigned                 fail_count;

    function new();
      int i;
      for (i = 0; i < NUM_ENTRIES; i++) begin
        ident[i] = '0;
        mask[i]  = '1;
        rtr[i]   = 1'b0;
        bound[i] = 1'b0;
      end
      active_cnt = canaf_pkg::ACT_RST;
      normal_on  = 1'b0;
      fail_count = 0;
    endfunction

    function int unsigned scan_count();
      return (active_cnt > NUM_ENTRIES) ? NUM_ENTRIES : int'(active_cnt);
    endfunction

    function void set_reg(logic idx, logic [canaf_pkg::APB_DW-1:0] value);
      if (idx == canaf_pkg::REG_ACTIVE) active_cnt = value[canaf_pkg::ACT_W-1:0];
      else normal_on = value[0];
    endfunction

    function logic [canaf_pkg::APB_DW-1:0] reg_value(logic idx);
      if (idx == canaf_pkg::REG_ACTIVE) return canaf_pkg::APB_DW'(active_cnt);
      return canaf_pkg::APB_DW'(normal_on);
    endfunction

    // work out the result of an accepted word and update the entry store
    function void note_word(in_word_t w);
      filter_result_t r;
      int unsigned    n;
      int unsigned    i;
      bit             zero_word;
      bit             hit;
      r.code = canaf_pkg::RS_NO_MATCH;
      r.hit  = '0;
      n = scan_count();
      if (w.mode == canaf_pkg::MODE_WRITE) begin
        if (w.entry_index < n) begin
          ident[w.entry_index] = w.entry_ident;
          mask[w.entry_index]  = w.entry_mask;
          rtr[w.entry_index]   = w.entry_rtr;
          bound[w.entry_index] = 1'b1;
          r.code = canaf_pkg::RS_WR_OK;
        end else begin
          r.code = canaf_pkg::RS_WR_REJ;
        end
      end else if (!normal_on) begin
        r.code = canaf_pkg::RS_IGNORED;
      end else if (w.frame_short) begin
        r.code = canaf_pkg::RS_RX_ERR;
      end else begin
        zero_word = (w.frame_id == '0) && !w.frame_err && !w.frame_rtr && !w.frame_eff;
        // first hit wins
        for (i = 0; i < n; i++) begin
          if (bound[i])
            hit = !w.frame_eff && (w.frame_rtr == rtr[i]) &&
                  (((w.frame_id[canaf_pkg::ID_W-1:0] ^ ident[i]) & mask[i]) == '0);
          else
            hit = zero_word;
          if (hit) begin
            r.code = bound[i] ? canaf_pkg::RS_DISPATCH : canaf_pkg::RS_UNBOUND;
            r.hit  = canaf_pkg::HIT_W'(i);
            break;
          end
        end
      end
      pending_results.push_back(r);
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t ns: %s", $realtime, msg);
      fail_count++;
    endtask

    // compare one result word with the oldest prediction
    task check_result(logic [canaf_pkg::STAT_W-1:0] status, logic [canaf_pkg::HIT_W-1:0] hit);
      filter_result_t want;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("status %0d hit %0d with no word pending", status, hit));
      end else begin
        want = pending_results.pop_front();
        if (status !== want.code)
          report_mismatch($sformatf("status %0d, predicted %0d", status, want.code));
        if (hit !== want.hit)
          report_mismatch($sformatf("hit_index %0d, predicted %0d", hit, want.hit));
      end
    endtask
  endclass

  logic                         clk_i;
  logic                         rst_ni;
  logic                         in_valid_i;
  logic                         in_stall_o;
  in_word_t                     cur_word;
  logic                         mode_i;
  logic [canaf_pkg::IDX_W-1:0]  entry_index_i;
  logic [canaf_pkg::ID_W-1:0]   entry_ident_i;
  logic [canaf_pkg::ID_W-1:0]   entry_mask_i;
  logic                         entry_rtr_i;
  logic [canaf_pkg::FID_W-1:0]  frame_id_i;
  logic                         frame_err_i;
  logic                         frame_rtr_i;
  logic                         frame_eff_i;
  logic                         frame_short_i;
  logic                         out_valid_o;
  logic                         out_stall_i;
  logic [canaf_pkg::STAT_W-1:0] status_o;
  logic [canaf_pkg::HIT_W-1:0]  hit_index_o;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [canaf_pkg::APB_AW-1:0] paddr;
  logic [canaf_pkg::APB_DW-1:0] pwdata;
  logic [canaf_pkg::APB_DW-1:0] prdata;
  logic                         pready;
  logic                         in_accept;
  logic                         out_accept;
  int unsigned                  send_idle_pct;
  int unsigned                  recv_idle_pct;
  acceptance_scoreboard         sb;

  // payload ports follow the current word
  assign mode_i        = cur_word.mode;
  assign entry_index_i = cur_word.entry_index;
  assign entry_ident_i = cur_word.entry_ident;
  assign entry_mask_i  = cur_word.entry_mask;
  assign entry_rtr_i   = cur_word.entry_rtr;
  assign frame_id_i    = cur_word.frame_id;
  assign frame_err_i   = cur_word.frame_err;
  assign frame_rtr_i   = cur_word.frame_rtr;
  assign frame_eff_i   = cur_word.frame_eff;
  assign frame_short_i = cur_word.frame_short;

  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_accept = out_valid_o && !out_stall_i;

  can_rx_acceptance_filter uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .mode_i        (mode_i),
    .entry_index_i (entry_index_i),
    .entry_ident_i (entry_ident_i),
    .entry_mask_i  (entry_mask_i),
    .entry_rtr_i   (entry_rtr_i),
    .frame_id_i    (frame_id_i),
    .frame_err_i   (frame_err_i),
    .frame_rtr_i   (frame_rtr_i),
    .frame_eff_i   (frame_eff_i),
    .frame_short_i (frame_short_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .hit_index_o   (hit_index_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // receiver stalls at random
  always @(negedge clk_i) begin
    out_stall_i = (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);
  end

  // both channels seen at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_accept) sb.check_result(status_o, hit_index_o);
      if (in_accept) sb.note_word(cur_word);
    end
  end

  // watchdog on handshake activity
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if (in_accept || out_accept || psel) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
    $display("Verification failed");
    $finish;
  end

  function automatic in_word_t frame_word(logic [canaf_pkg::FID_W-1:0] id, logic err,
                                          logic rtr, logic eff, logic shrt);
    in_word_t w;
    w             = '0;
    w.mode        = canaf_pkg::MODE_FRAME;
    w.frame_id    = id;
    w.frame_err   = err;
    w.frame_rtr   = rtr;
    w.frame_eff   = eff;
    w.frame_short = shrt;
    return w;
  endfunction

  function automatic in_word_t entry_word(logic [canaf_pkg::IDX_W-1:0] idx,
                                          logic [canaf_pkg::ID_W-1:0] ident,
                                          logic [canaf_pkg::ID_W-1:0] msk, logic rtr);
    in_word_t w;
    w             = '0;
    w.mode        = canaf_pkg::MODE_WRITE;
    w.entry_index = idx;
    w.entry_ident = ident;
    w.entry_mask  = msk;
    w.entry_rtr   = rtr;
    return w;
  endfunction

  // random word: mostly entry writes and frames aimed at a live entry
  function automatic in_word_t gen_word();
    in_word_t                   w;
    int unsigned                roll;
    int unsigned                n;
    int unsigned                e;
    logic [canaf_pkg::ID_W-1:0] free_bits;
    n    = sb.scan_count();
    roll = $urandom_range(99);
    w.mode        = canaf_pkg::MODE_FRAME;
    w.entry_index = canaf_pkg::IDX_W'($urandom);
    w.entry_ident = canaf_pkg::ID_W'($urandom);
    w.entry_mask  = canaf_pkg::ID_W'($urandom);
    w.entry_rtr   = 1'($urandom_range(1));
    w.frame_id    = canaf_pkg::FID_W'($urandom);
    w.frame_err   = 1'($urandom_range(1));
    w.frame_rtr   = 1'($urandom_range(1));
    w.frame_eff   = 1'($urandom_range(1));
    w.frame_short = 1'($urandom_range(1));
    if (roll < 30) begin
      w.mode = canaf_pkg::MODE_WRITE;
      if (n != 0 && roll < 26) w.entry_index = canaf_pkg::IDX_W'($urandom_range(n - 1));
    end else if (roll < 72 && n != 0) begin
      e = $urandom_range(n - 1);
      w.frame_short = ($urandom_range(19) == 0);
      if (sb.bound[e]) begin
        free_bits = canaf_pkg::ID_W'($urandom);
        w.frame_id  = {UPPER_W'($urandom),
                       (sb.ident[e] & sb.mask[e]) | (free_bits & ~sb.mask[e])};
        w.frame_rtr = sb.rtr[e];
        w.frame_eff = 1'b0;
      end else begin
        w.frame_id  = '0;
        w.frame_err = 1'b0;
        w.frame_rtr = 1'b0;
        w.frame_eff = 1'b0;
      end
    end else if (roll < 80) begin
      w.frame_id    = '0;
      w.frame_err   = 1'b0;
      w.frame_rtr   = 1'b0;
      w.frame_eff   = 1'b0;
      w.frame_short = 1'b0;
    end else begin
      w.mode = 1'($urandom_range(1));
    end
    return w;
  endfunction

  // present one word and hold it until taken; starts and ends just after a falling edge
  task automatic send_word(in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    cur_word   = w;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // drop valid and wait until every predicted word has come back
  task automatic settle();
    in_valid_i = 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic apb_access(logic wr, logic idx, logic [canaf_pkg::APB_DW-1:0] wdata,
                            output logic [canaf_pkg::APB_DW-1:0] rdata);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = canaf_pkg::APB_AW'({idx, 2'b00});
    pwdata  = wdata;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // register write at idle, then read back
  task automatic reg_write(logic idx, logic [canaf_pkg::APB_DW-1:0] value);
    logic [canaf_pkg::APB_DW-1:0] rd;
    settle();
    apb_access(1'b1, idx, value, rd);
    sb.set_reg(idx, value);
    apb_access(1'b0, idx, '0, rd);
    if (rd !== sb.reg_value(idx))
      sb.report_mismatch($sformatf("register %0d reads %0h, written %0h", idx, rd,
                                   sb.reg_value(idx)));
  endtask

  task automatic run_random(int unsigned words, int unsigned act, logic nm,
                            int unsigned snd_pct, int unsigned rcv_pct);
    reg_write(canaf_pkg::REG_ACTIVE, act);
    reg_write(canaf_pkg::REG_NORMAL, canaf_pkg::APB_DW'(nm));
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    repeat (words) send_word(gen_word());
  endtask

  initial begin
    sb            = new();
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    cur_word      = '0;
    out_stall_i   = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // frames ignored while not in normal mode, short read too; writes still land
    send_word(frame_word(29'h1FFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b1));
    send_word(entry_word(5'd3, 11'h7FF, 11'h7FF, 1'b1));
    reg_write(canaf_pkg::REG_NORMAL, 32'd1);
    // zero word hits an unbound entry, short read, nothing matches
    send_word(frame_word('0, 1'b0, 1'b0, 1'b0, 1'b0));
    send_word(frame_word('0, 1'b0, 1'b0, 1'b0, 1'b1));
    send_word(frame_word(29'h123, 1'b0, 1'b0, 1'b0, 1'b0));
    // bound entry: upper id bits and error flag not compared, extended never hits
    send_word(entry_word(5'd0, 11'h7FF, 11'h7FF, 1'b1));
    send_word(frame_word(29'h7FF, 1'b0, 1'b1, 1'b0, 1'b0));
    send_word(frame_word(29'h1FFF_F7FF, 1'b1, 1'b1, 1'b0, 1'b0));
    send_word(frame_word(29'h7FF, 1'b0, 1'b1, 1'b1, 1'b0));
    send_word(frame_word('0, 1'b0, 1'b0, 1'b0, 1'b0));
    // masks: full, partial, none on the last entry
    send_word(entry_word(5'd31, 11'h000, 11'h000, 1'b0));
    send_word(entry_word(5'd1, 11'h2AA, 11'h7FF, 1'b0));
    send_word(entry_word(5'd2, 11'h555, 11'h0F0, 1'b0));
    send_word(frame_word(29'h2AA, 1'b0, 1'b0, 1'b0, 1'b0));
    send_word(frame_word(29'h050, 1'b0, 1'b0, 1'b0, 1'b0));
    send_word(frame_word(29'h001, 1'b0, 1'b0, 1'b0, 1'b0));
    // active count above bank size acts as full bank
    reg_write(canaf_pkg::REG_ACTIVE, 32'd63);
    send_word(entry_word(5'd31, 11'h400, 11'h400, 1'b1));
    send_word(frame_word(29'h7FF, 1'b0, 1'b1, 1'b0, 1'b0));
    // no active entries: every write rejected, nothing matches
    reg_write(canaf_pkg::REG_ACTIVE, 32'd0);
    send_word(entry_word(5'd0, 11'h001, 11'h7FF, 1'b0));
    send_word(frame_word('0, 1'b0, 1'b0, 1'b0, 1'b0));
    // single entry
    reg_write(canaf_pkg::REG_ACTIVE, 32'd1);
    send_word(entry_word(5'd1, 11'h001, 11'h7FF, 1'b0));
    send_word(entry_word(5'd0, 11'h7FF, 11'h7FF, 1'b0));
    send_word(frame_word(29'h7FF, 1'b0, 1'b0, 1'b0, 1'b0));
    send_word(frame_word('0, 1'b0, 1'b0, 1'b0, 1'b0));

    // random part: sender idles less than receiver, then the reverse, then no idling
    run_random(350, 32, 1'b1, 33, 55);
    run_random(200, 63, 1'b1, 33, 55);
    run_random(250, $urandom_range(31, 2), 1'b1, 55, 33);
    run_random(100, 1, 1'b1, 55, 33);
    run_random(60, 32, 1'b0, 0, 0);
    run_random(40, 0, 1'b1, 0, 0);
    run_random(500, 32, 1'b1, 0, 0);

    // drain and let the block go quiet
    in_valid_i = 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk_i);
    repeat (TAIL) @(negedge clk_i);
    if (sb.fail_count == 0 && sb.pending_results.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// ----- sim.f -----
sv/canaf_pkg.sv
sv/canaf_ram.sv
sv/canaf_ctrl.sv
sv/canaf_dp.sv
sv/can_rx_acceptance_filter.sv
sim/testbench.sv
